### sv/ple_pkg.sv
// Package: shared sizes, codes and the result request type of the list engine.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

  localparam int DEPTH  = 32;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 6;
  localparam int ACT_W  = 3;
  localparam int CMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  typedef enum logic [ACT_W-1:0] {
    A_INS_FRONT = 3'd0,
    A_INS_BACK  = 3'd1,
    A_INS_POS   = 3'd2,
    A_DEL_FRONT = 3'd3,
    A_DEL_BACK  = 3'd4,
    A_DEL_POS   = 3'd5,
    A_SEARCH    = 3'd6,
    A_READ_OUT  = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS,
    S_DEL,
    S_WALK,
    S_RESP
  } state_t;

  // One result handed from the sequencer to the output register.
  typedef struct packed {
    logic             load;
    status_t          status;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic             last;
  } result_t;

endpackage
`default_nettype wire

### sv/ple_ram.sv
// Generic synchronous RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/ple_seq.sv
// Sequencer: decodes a request, shifts entries in the RAM, walks it for search and read-out.
`timescale 1ns / 1ps
`default_nettype none
module ple_seq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic [ple_pkg::ACT_W-1:0]   action,
  input  wire logic [ple_pkg::POS_W-1:0]   position,
  input  wire logic [ple_pkg::VAL_W-1:0]   value,
  input  wire logic                        out_free,
  output      ple_pkg::result_t            res,
  output      logic                        ram_we,
  output      logic [ple_pkg::IDX_W-1:0]   ram_waddr,
  output      logic [ple_pkg::VAL_W-1:0]   ram_wdata,
  output      logic                        ram_re,
  output      logic [ple_pkg::IDX_W-1:0]   ram_raddr,
  input  wire logic [ple_pkg::VAL_W-1:0]   ram_rdata
);

  ple_pkg::state_t            state, state_next;
  ple_pkg::action_t           act;
  logic [ple_pkg::POS_W-1:0]  pos;
  logic [ple_pkg::VAL_W-1:0]  val;
  logic [ple_pkg::LEN_W-1:0]  len, len_next;
  logic [ple_pkg::LEN_W-1:0]  cur, cur_next;
  logic [ple_pkg::LEN_W-1:0]  idx, idx_next;
  logic [ple_pkg::LEN_W-1:0]  wa, wa_next;
  logic                       wr_pend, wr_pend_next;
  logic                       rd_pend, rd_pend_next;
  logic [ple_pkg::LEN_W-1:0]  rpos, rpos_next;
  logic                       hold_valid, hold_valid_next;
  logic [ple_pkg::LEN_W-1:0]  hold_pos, hold_pos_next;
  logic [ple_pkg::VAL_W-1:0]  hold_val, hold_val_next;
  ple_pkg::status_t           resp_status, resp_status_next;

  logic [ple_pkg::CMP_W-1:0]  pos_c;
  logic [ple_pkg::CMP_W-1:0]  len_c;
  logic [ple_pkg::LEN_W-1:0]  rpos_1;
  logic [ple_pkg::LEN_W-1:0]  cur_1;
  logic                       proc_ok;
  logic                       match;
  logic                       accept;

  assign in_stall = (state != ple_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign pos_c    = ple_pkg::CMP_W'(pos);
  assign len_c    = ple_pkg::CMP_W'(len);
  assign rpos_1   = rpos + ple_pkg::LEN_W'(1);
  assign cur_1    = cur + ple_pkg::LEN_W'(1);
  assign match    = (ram_rdata == val);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ple_pkg::S_IDLE;
      len        <= '0;
      wr_pend    <= 1'b0;
      rd_pend    <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      state      <= state_next;
      len        <= len_next;
      wr_pend    <= wr_pend_next;
      rd_pend    <= rd_pend_next;
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act <= ple_pkg::action_t'(action);
      pos <= position;
      val <= value;
    end
    cur         <= cur_next;
    idx         <= idx_next;
    wa          <= wa_next;
    rpos        <= rpos_next;
    hold_pos    <= hold_pos_next;
    hold_val    <= hold_val_next;
    resp_status <= resp_status_next;
  end

  always_comb begin
    state_next       = state;
    len_next         = len;
    cur_next         = cur;
    idx_next         = idx;
    wa_next          = wa;
    wr_pend_next     = wr_pend;
    rd_pend_next     = rd_pend;
    rpos_next        = rpos;
    hold_valid_next  = hold_valid;
    hold_pos_next    = hold_pos;
    hold_val_next    = hold_val;
    resp_status_next = resp_status;
    res              = '0;
    ram_we           = 1'b0;
    ram_waddr        = wa[ple_pkg::IDX_W-1:0];
    ram_wdata        = ram_rdata;
    ram_re           = 1'b0;
    ram_raddr        = cur[ple_pkg::IDX_W-1:0];
    proc_ok          = 1'b1;

    case (state)
      ple_pkg::S_IDLE: begin
        if (accept) begin
          state_next = ple_pkg::S_DECODE;
        end
      end

      ple_pkg::S_DECODE: begin
        wr_pend_next    = 1'b0;
        rd_pend_next    = 1'b0;
        hold_valid_next = 1'b0;
        state_next      = ple_pkg::S_RESP;
        case (act)
          ple_pkg::A_INS_FRONT, ple_pkg::A_INS_BACK, ple_pkg::A_INS_POS: begin
            if (act == ple_pkg::A_INS_POS &&
                (pos_c == '0 || pos_c > len_c + ple_pkg::CMP_W'(1))) begin
              resp_status_next = ple_pkg::ST_BADPOS;
            end else if (len_c >= ple_pkg::CMP_W'(ple_pkg::DEPTH)) begin
              resp_status_next = ple_pkg::ST_FULL;
            end else begin
              if (act == ple_pkg::A_INS_FRONT) begin
                idx_next = '0;
              end else if (act == ple_pkg::A_INS_BACK) begin
                idx_next = len;
              end else begin
                idx_next = ple_pkg::LEN_W'(pos_c - ple_pkg::CMP_W'(1));
              end
              cur_next   = len;
              state_next = ple_pkg::S_INS;
            end
          end
          ple_pkg::A_DEL_FRONT, ple_pkg::A_DEL_BACK, ple_pkg::A_DEL_POS: begin
            if (len == '0) begin
              resp_status_next = ple_pkg::ST_EMPTY;
            end else if (act == ple_pkg::A_DEL_POS && (pos_c == '0 || pos_c > len_c)) begin
              resp_status_next = ple_pkg::ST_BADPOS;
            end else begin
              if (act == ple_pkg::A_DEL_FRONT) begin
                cur_next = '0;
              end else if (act == ple_pkg::A_DEL_BACK) begin
                cur_next = len - ple_pkg::LEN_W'(1);
              end else begin
                cur_next = ple_pkg::LEN_W'(pos_c - ple_pkg::CMP_W'(1));
              end
              state_next = ple_pkg::S_DEL;
            end
          end
          default: begin
            if (len == '0) begin
              resp_status_next = ple_pkg::ST_EMPTY;
            end else begin
              cur_next   = '0;
              state_next = ple_pkg::S_WALK;
            end
          end
        endcase
      end

      // shift toward the back, highest entry first, then drop the new value in
      ple_pkg::S_INS: begin
        if (wr_pend) begin
          ram_we = 1'b1;
        end else if (cur == idx) begin
          ram_we           = 1'b1;
          ram_waddr        = idx[ple_pkg::IDX_W-1:0];
          ram_wdata        = val;
          len_next         = len + ple_pkg::LEN_W'(1);
          resp_status_next = ple_pkg::ST_OK;
          state_next       = ple_pkg::S_RESP;
        end
        if (cur > idx) begin
          ram_re       = 1'b1;
          ram_raddr    = ple_pkg::IDX_W'(cur - ple_pkg::LEN_W'(1));
          wa_next      = cur;
          cur_next     = cur - ple_pkg::LEN_W'(1);
          wr_pend_next = 1'b1;
        end else begin
          wr_pend_next = 1'b0;
        end
      end

      // shift toward the front, lowest entry first
      ple_pkg::S_DEL: begin
        if (wr_pend) begin
          ram_we = 1'b1;
        end
        if (cur_1 < len) begin
          ram_re       = 1'b1;
          ram_raddr    = cur_1[ple_pkg::IDX_W-1:0];
          wa_next      = cur;
          cur_next     = cur_1;
          wr_pend_next = 1'b1;
        end else begin
          wr_pend_next = 1'b0;
          if (!wr_pend) begin
            len_next         = len - ple_pkg::LEN_W'(1);
            resp_status_next = ple_pkg::ST_OK;
            state_next       = ple_pkg::S_RESP;
          end
        end
      end

      ple_pkg::S_WALK: begin
        if (rd_pend) begin
          if (act == ple_pkg::A_READ_OUT) begin
            proc_ok    = out_free;
            res.load   = out_free;
            res.status = ple_pkg::ST_OK;
            res.pos    = ple_pkg::POS_W'(rpos_1);
            res.val    = ram_rdata;
            res.last   = (rpos_1 == len);
          end else if (match) begin
            // a newer match shows the held one was not the last
            if (hold_valid) begin
              proc_ok    = out_free;
              res.load   = out_free;
              res.status = ple_pkg::ST_OK;
              res.pos    = ple_pkg::POS_W'(hold_pos);
              res.val    = hold_val;
              res.last   = 1'b0;
            end
            if (proc_ok) begin
              hold_valid_next = 1'b1;
              hold_pos_next   = rpos_1;
              hold_val_next   = ram_rdata;
            end
          end
        end
        if (proc_ok) begin
          if (cur < len) begin
            ram_re       = 1'b1;
            rpos_next    = cur;
            cur_next     = cur_1;
            rd_pend_next = 1'b1;
          end else begin
            rd_pend_next = 1'b0;
          end
        end
        if (!rd_pend && cur >= len) begin
          if (act == ple_pkg::A_READ_OUT) begin
            state_next = ple_pkg::S_IDLE;
          end else if (out_free) begin
            res.load   = 1'b1;
            res.last   = 1'b1;
            if (hold_valid) begin
              res.status = ple_pkg::ST_OK;
              res.pos    = ple_pkg::POS_W'(hold_pos);
              res.val    = hold_val;
            end else begin
              res.status = ple_pkg::ST_NOTFOUND;
            end
            state_next = ple_pkg::S_IDLE;
          end
        end
      end

      ple_pkg::S_RESP: begin
        if (out_free) begin
          res.load   = 1'b1;
          res.status = resp_status;
          res.last   = 1'b1;
          state_next = ple_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ple_pkg::S_IDLE;
      end
    endcase
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= ple_pkg::LEN_W'(ple_pkg::DEPTH))
    else $error("list length beyond capacity");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ple_pkg::S_IDLE) |-> !ram_we)
    else $error("RAM written while idle");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res.load |-> out_free)
    else $error("result loaded into a busy output register");

  a_read_in_list: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (ple_pkg::LEN_W'(ram_raddr) < len))
    else $error("RAM read beyond list length");

endmodule
`default_nettype wire

### sv/positional_list_engine.sv
// Top level: ordered list engine with RAM, sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to 32 signed 32-bit values, kept in list order in one RAM
// (one write port, one read port, registered read data). A request is taken
// only while the engine is idle, so one request is in work at a time. A
// rejected request (empty, full, bad position) goes from decode straight to
// the response state, which loads its result into the output register. An
// update that moves m entries (a positional insert moves every entry from
// the insert point on, a delete every entry after the removed one, one
// entry per cycle through the RAM read and write ports) then loads its ok
// result. Search and read-out stream the list through the RAM read port at
// one entry per cycle while the output register is free; a read-out gives
// one transaction per entry with last on the final one, a search gives one
// per match with last on the final match, or a single not-found transaction.
// Output stalls pause the walk without loss. A result waits in the output
// register, which the engine keeps filling when it is taken in the same
// cycle. The RAM needs no clearing after reset: only entries below the
// current length are ever read.
module positional_list_engine (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [ple_pkg::ACT_W-1:0] action,
  input  wire logic [ple_pkg::POS_W-1:0] position,
  input  wire logic signed [ple_pkg::VAL_W-1:0] value,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      logic [2:0]                status,
  output      logic [ple_pkg::POS_W-1:0] position_out,
  output      logic signed [ple_pkg::VAL_W-1:0] value_out,
  output      logic                      last
);

  ple_pkg::result_t           res;
  logic                       out_free;
  logic                       ram_we;
  logic [ple_pkg::IDX_W-1:0]  ram_waddr;
  logic [ple_pkg::VAL_W-1:0]  ram_wdata;
  logic                       ram_re;
  logic [ple_pkg::IDX_W-1:0]  ram_raddr;
  logic [ple_pkg::VAL_W-1:0]  ram_rdata;
  ple_pkg::status_t           out_status;

  // The output register frees up when empty or when its transaction is taken.
  assign out_free = !out_valid || !out_stall;

  ple_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .position  (position),
    .value     (value),
    .out_free  (out_free),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // List storage, one entry per list position.
  ple_ram #(
    .WIDTH (ple_pkg::VAL_W),
    .DEPTH (ple_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: valid is control, payload loads only with a new result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_status   <= res.status;
      position_out <= res.pos;
      value_out    <= res.val;
      last         <= res.last;
    end
  end

  assign status = out_status;

endmodule
`default_nettype wire

### test/ple_checker.sv
// Checker: watches both channels of the list engine, predicts each result and compares.
`timescale 1ns / 1ps
module ple_checker
  import ple_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [ACT_W-1:0]        action,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [2:0]              status,
  input  logic [POS_W-1:0]        position_out,
  input  logic signed [VAL_W-1:0] value_out,
  input  logic                    last,
  output int                      errors,
  output int                      pending,
  output int                      checked,
  output int                      peak_len
);

  typedef struct {
    status_t                 status;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    logic                    last;
  } reply_t;

  // Shadow copy of the list, in list order.
  logic signed [VAL_W-1:0] list_vals [DEPTH];
  int                      list_len;
  reply_t                  replies_q [$];
  reply_t                  want;

  function void queue_reply(status_t st, int pos, logic signed [VAL_W-1:0] v, logic lst);
    reply_t r;
    r.status = st;
    r.pos    = pos[POS_W-1:0];
    r.val    = v;
    r.last   = lst;
    replies_q.push_back(r);
  endfunction

  // Apply one request to the shadow list and queue the replies it causes.
  task automatic apply_request(input action_t act, input logic [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] v);
    int idx;
    int i;
    int hits;
    int seen;
    case (act)
      A_INS_FRONT, A_INS_BACK, A_INS_POS: begin
        if (act == A_INS_POS && (pos < 1 || int'(pos) > list_len + 1)) begin
          queue_reply(ST_BADPOS, 0, 0, 1'b1);
        end else if (list_len >= DEPTH) begin
          queue_reply(ST_FULL, 0, 0, 1'b1);
        end else begin
          if (act == A_INS_FRONT) idx = 0;
          else if (act == A_INS_BACK) idx = list_len;
          else idx = int'(pos) - 1;
          for (i = list_len; i > idx; i--) list_vals[i] = list_vals[i-1];
          list_vals[idx] = v;
          list_len++;
          queue_reply(ST_OK, 0, 0, 1'b1);
        end
      end
      A_DEL_FRONT, A_DEL_BACK, A_DEL_POS: begin
        if (list_len == 0) begin
          queue_reply(ST_EMPTY, 0, 0, 1'b1);
        end else if (act == A_DEL_POS && (pos < 1 || int'(pos) > list_len)) begin
          queue_reply(ST_BADPOS, 0, 0, 1'b1);
        end else begin
          if (act == A_DEL_FRONT) idx = 0;
          else if (act == A_DEL_BACK) idx = list_len - 1;
          else idx = int'(pos) - 1;
          for (i = idx; i < list_len - 1; i++) list_vals[i] = list_vals[i+1];
          list_len--;
          queue_reply(ST_OK, 0, 0, 1'b1);
        end
      end
      A_SEARCH: begin
        if (list_len == 0) begin
          queue_reply(ST_EMPTY, 0, 0, 1'b1);
        end else begin
          hits = 0;
          for (i = 0; i < list_len; i++) if (list_vals[i] == v) hits++;
          if (hits == 0) begin
            queue_reply(ST_NOTFOUND, 0, 0, 1'b1);
          end else begin
            seen = 0;
            for (i = 0; i < list_len; i++) begin
              if (list_vals[i] == v) begin
                seen++;
                queue_reply(ST_OK, i + 1, list_vals[i], seen == hits);
              end
            end
          end
        end
      end
      default: begin
        if (list_len == 0) begin
          queue_reply(ST_EMPTY, 0, 0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++)
            queue_reply(ST_OK, i + 1, list_vals[i], i == list_len - 1);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      list_len = 0;
      replies_q.delete();
      errors   = 0;
      checked  = 0;
      peak_len = 0;
    end else begin
      // A request is only taken when idle, so check the result side first.
      if (out_valid && !out_stall) begin
        if (replies_q.size() == 0) begin
          $error("unexpected result: status %0d position %0d value %0d last %0b",
                 status, position_out, value_out, last);
          errors++;
        end else begin
          want = replies_q.pop_front();
          checked++;
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
          end
          if (position_out !== want.pos) begin
            $error("position_out: expected %0d, actual %0d", want.pos, position_out);
            errors++;
          end
          if (value_out !== want.val) begin
            $error("value_out: expected %0d, actual %0d", want.val, value_out);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(action_t'(action), position, value);
        if (list_len > peak_len) peak_len = list_len;
      end
    end
    pending = replies_q.size();
  end

endmodule

### test/tb_positional_list_engine.sv
// Testbench top: drives requests and result stalls into the list engine and reports the verdict.
`timescale 1ns / 1ps
module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int LIMIT        = 1000000;  // cycles before the run is declared hung
  localparam int DRAIN        = 48;       // wait after the last expected result for stray transactions
  localparam int RANDOM_ITEMS = 246;

  // Bias of one random round: how the action mix pushes the list length.
  typedef enum int {
    B_GROW,
    B_SHRINK,
    B_MIXED
  } bias_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [ACT_W-1:0]        action;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;
  logic                    out_valid;
  logic                    out_stall;
  logic [2:0]              status;
  logic [POS_W-1:0]        position_out;
  logic signed [VAL_W-1:0] value_out;
  logic                    last;

  int fail_count;
  int open_count;
  int result_count;
  int peak_len;
  int requests = 0;
  int cycles   = 0;
  bit quiet    = 1'b0;  // when set, both sides run back to back with no idling

  always #4 clk = ~clk;

  positional_list_engine u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .position     (position),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .position_out (position_out),
    .value_out    (value_out),
    .last         (last)
  );

  ple_checker u_list_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .position     (position),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .position_out (position_out),
    .value_out    (value_out),
    .last         (last),
    .errors       (fail_count),
    .pending      (open_count),
    .checked      (result_count),
    .peak_len     (peak_len)
  );

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: after each accepted transaction draw a random stall length,
  // and hold stall for that length whether or not a result waits.
  initial begin : result_stall
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) hold = quiet ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Values: mostly a small pool so searches find duplicates, plus the
  // extremes and fully random words so every bit toggles.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0, 1: return $signed($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Positions: mostly near the valid range, sometimes anywhere in 0..63.
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 63));
    return POS_W'($urandom_range(1, DEPTH + 2));
  endfunction

  function automatic action_t pick_action(bias_t b);
    int r;
    int ins_cut;
    int del_cut;
    r = $urandom_range(0, 99);
    case (b)
      B_GROW:   begin ins_cut = 85; del_cut = 90; end
      B_SHRINK: begin ins_cut = 15; del_cut = 75; end
      default:  begin ins_cut = 38; del_cut = 70; end
    endcase
    if (r < ins_cut) return action_t'($urandom_range(0, 2));
    if (r < del_cut) return action_t'($urandom_range(3, 5));
    return action_t'($urandom_range(6, 7));
  endfunction

  // Present one request at a falling edge and hold it until accepted.
  // Enter and leave at a falling edge; valid stays high across back-to-back items.
  task automatic send_request(input action_t act, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    position <= pos;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    bias_t bias;
    int    round_len;
    int    sent;
    int    round;

    rst      = 1'b1;
    in_valid = 1'b0;
    action   = A_INS_FRONT;
    position = '0;
    value    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reads, searches and deletes on an empty list first.
    send_request(A_READ_OUT,  0, 0);
    send_request(A_SEARCH,    0, 7);
    send_request(A_DEL_FRONT, 0, 0);
    send_request(A_DEL_BACK,  0, 0);
    send_request(A_DEL_POS,   1, 0);
    // Positional inserts outside 1..length+1 are rejected.
    send_request(A_INS_POS,   0, 9);
    send_request(A_INS_POS,   2, 9);
    // First insert at the back must count like any other insert.
    send_request(A_INS_BACK,  0, 32'h7fff_ffff);
    send_request(A_INS_FRONT, 0, 32'h8000_0000);
    send_request(A_INS_POS,   3, -1);
    send_request(A_INS_POS,   1, 0);
    send_request(A_INS_POS,  63, 5);
    send_request(A_INS_BACK,  0, -1);
    // List is now 0, min, max, -1, -1: search for duplicates and a miss.
    send_request(A_SEARCH,    0, -1);
    send_request(A_SEARCH,    0, 12345);
    send_request(A_READ_OUT,  0, 0);
    // Bad delete positions, then deletes at the tail, middle and both ends.
    send_request(A_DEL_POS,   0, 0);
    send_request(A_DEL_POS,  63, 0);
    send_request(A_DEL_POS,   6, 0);
    send_request(A_DEL_POS,   5, 0);
    send_request(A_DEL_POS,   2, 0);
    send_request(A_DEL_BACK,  0, 0);
    send_request(A_DEL_FRONT, 0, 0);
    send_request(A_READ_OUT,  0, 0);

    // Random rounds: the first one fills the list to the full case, later
    // ones pick a bias at random; some rounds run with no idling at all.
    sent  = 0;
    round = 0;
    while (sent < RANDOM_ITEMS) begin
      bias      = (round == 0) ? B_GROW : bias_t'($urandom_range(0, 2));
      round_len = (round == 0) ? 70 : $urandom_range(20, 40);
      if (round_len > RANDOM_ITEMS - sent) round_len = RANDOM_ITEMS - sent;
      quiet     = (round != 0) && ($urandom_range(0, 3) == 0);
      repeat (round_len) send_request(pick_action(bias), pick_position(), pick_value());
      sent += round_len;
      round++;
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // Drain: wait for every expected result, then give the engine time to
    // show any stray transaction.
    while (open_count != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Ran %0d requests over %0d random rounds; checked %0d result transactions.",
             requests, round, result_count);
    $display("List length peaked at %0d of %0d entries.", peak_len, DEPTH);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
sv/ple_pkg.sv
sv/ple_ram.sv
sv/ple_seq.sv
sv/positional_list_engine.sv
test/ple_checker.sv
test/tb_positional_list_engine.sv
